[src/escape_time_fractal_pixel_core_macros.svh]
// assertion macros for the escape time fractal pixel core checker
// needs clk and rst visible at the point of use
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_CORE_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_CORE_MACROS_SVH

// clocked assertion, off while reset is high
`define ETF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ETF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/etf_pkg.sv]
// shared types, constants and helpers for the escape time fractal pixel core
// no dependencies
package etf_pkg;

  localparam int FRAC_BITS = 28;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_RE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_IM = 3'd7;

  localparam logic MODE_MANDELBROT = 1'b0;
  localparam logic MODE_JULIA      = 1'b1;

  localparam logic [CNT_W-1:0]   RST_MAX_ITER = 16'd2048;
  localparam logic signed [31:0] RST_X_ORIGIN = -32'sd671088640;
  localparam logic signed [31:0] RST_Y_ORIGIN = -32'sd348966092;
  localparam logic [30:0]        RST_X_STEP   = 31'd917504;
  localparam logic [30:0]        RST_Y_STEP   = 31'd681574;

  // |z|^2 escape bound, 4.0 in Q8.56
  localparam logic [63:0] ESCAPE_SQ = 64'd4 << 56;

  typedef struct packed {
    logic                 mode;
    logic [CNT_W-1:0]     max_iter;
    logic signed [31:0]   x_origin;
    logic signed [31:0]   y_origin;
    logic [30:0]          x_step;
    logic [30:0]          y_step;
    logic signed [31:0]   julia_re;
    logic signed [31:0]   julia_im;
  } cfg_t;

  function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [63:0] sext64(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

[src/escape_time_fractal_pixel_core.sv]
// escape time fractal pixel core: sequencer and datapath around one multiplier
// depends on etf_pkg, etf_mul, etf_cfg
//
// usage
// - a transaction is accepted at a clock edge with start high and busy low;
//   col and row are captured then and echoed on out_col / out_row
// - the result (out_col, out_row, escape_count, in_set) is valid for exactly
//   one cycle while done is high; the receiver cannot stall it
// - configuration: cfg_we, cfg_index, cfg_data write one register per edge;
//   the user must write only while busy is low, the core does not enforce it
// - sequence, all around the single shared 32x32 multiplier: point setup in
//   S_CX, S_CY and S_CI, then per iteration S_MXX (x*x), S_MYY (y*y),
//   S_MXY (x*y) and S_UPD (the update)
// - a pixel ends in S_UPD at the limit or in S_MXY on escape; a limit of
//   zero ends in S_CI before any iteration
// - busy stays high from the accept edge until the cycle done is shown;
//   a new transaction may be accepted in that done cycle
// - reset clears the sequencer and loads the default register values
module escape_time_fractal_pixel_core #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [etf_pkg::IDX_W-1:0]     col,
  input  logic [etf_pkg::IDX_W-1:0]     row,
  output logic                          done,
  output logic [etf_pkg::IDX_W-1:0]     out_col,
  output logic [etf_pkg::IDX_W-1:0]     out_row,
  output logic [etf_pkg::CNT_W-1:0]     escape_count,
  output logic                          in_set,
  input  logic                          cfg_we,
  input  logic [etf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [etf_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CX   = 3'd1;
  localparam logic [2:0] S_CY   = 3'd2;
  localparam logic [2:0] S_CI   = 3'd3;
  localparam logic [2:0] S_MXX  = 3'd4;
  localparam logic [2:0] S_MYY  = 3'd5;
  localparam logic [2:0] S_MXY  = 3'd6;
  localparam logic [2:0] S_UPD  = 3'd7;

  localparam logic [etf_pkg::IDX_W-1:0] IDX_CLAMP = etf_pkg::IDX_W'(MAX_SIDE - 1);

  etf_pkg::cfg_t cfg;

  logic [2:0]                     state;
  logic [2:0]                     state_next;
  logic [etf_pkg::IDX_W-1:0]      col_q;
  logic [etf_pkg::IDX_W-1:0]      row_q;
  logic [etf_pkg::IDX_W-1:0]      col_c;
  logic [etf_pkg::IDX_W-1:0]      row_c;
  logic signed [31:0]             px;
  logic signed [31:0]             py;
  logic signed [31:0]             x;
  logic signed [31:0]             y;
  logic signed [31:0]             cr;
  logic signed [31:0]             ci;
  logic [63:0]                    xx;
  logic [etf_pkg::CNT_W-1:0]      count;
  logic [etf_pkg::CNT_W-1:0]      count_inc;
  logic signed [31:0]             mul_a;
  logic signed [31:0]             mul_b;
  logic signed [63:0]             prod;
  logic [63:0]                    mag_sq;
  logic signed [63:0]             diff;
  logic signed [31:0]             x_new;
  logic signed [31:0]             y_new;
  logic                           fin;
  logic [etf_pkg::CNT_W-1:0]      fin_count;

  etf_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  etf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // index clamp for the point only
  assign col_c = (32'(col_q) >= MAX_SIDE) ? IDX_CLAMP : col_q;
  assign row_c = (32'(row_q) >= MAX_SIDE) ? IDX_CLAMP : row_q;

  always_comb begin
    unique case (state)
      S_CX: begin
        mul_a = {1'b0, cfg.x_step};
        mul_b = {{(32 - etf_pkg::IDX_W){1'b0}}, col_c};
      end
      S_CY: begin
        mul_a = {1'b0, cfg.y_step};
        mul_b = {{(32 - etf_pkg::IDX_W){1'b0}}, row_c};
      end
      S_MXX: begin
        mul_a = x;
        mul_b = x;
      end
      S_MYY: begin
        mul_a = y;
        mul_b = y;
      end
      default: begin
        mul_a = x;
        mul_b = y;
      end
    endcase
  end

  // in the update cycle xx holds x*x - y*y and prod holds x*y
  assign py        = etf_pkg::sat_q(etf_pkg::sext64(cfg.y_origin) + prod);
  assign mag_sq    = xx + prod;
  assign diff      = $signed(xx - prod);
  assign x_new     = etf_pkg::sat_q(($signed(xx) >>> etf_pkg::FRAC_BITS)
                                    + etf_pkg::sext64(cr));
  assign y_new     = etf_pkg::sat_q((prod >>> (etf_pkg::FRAC_BITS - 1))
                                    + etf_pkg::sext64(ci));
  assign count_inc = count + 1'b1;

  always_comb begin
    state_next = state;
    fin        = 1'b0;
    fin_count  = count;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CX;
        end
      end
      S_CX:  state_next = S_CY;
      S_CY:  state_next = S_CI;
      S_CI: begin
        if (cfg.max_iter == '0) begin
          fin        = 1'b1;
          fin_count  = '0;
          state_next = S_IDLE;
        end else begin
          state_next = S_MXX;
        end
      end
      S_MXX: state_next = S_MYY;
      S_MYY: state_next = S_MXY;
      S_MXY: begin
        if (mag_sq >= etf_pkg::ESCAPE_SQ) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        if (count_inc == cfg.max_iter) begin
          fin        = 1'b1;
          fin_count  = count_inc;
          state_next = S_IDLE;
        end else begin
          state_next = S_MXX;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      col_q <= col;
      row_q <= row;
    end
    if (state == S_CY) begin
      px <= etf_pkg::sat_q(etf_pkg::sext64(cfg.x_origin) + prod);
    end
    if (state == S_CI) begin
      count <= '0;
      if (cfg.mode == etf_pkg::MODE_JULIA) begin
        x  <= px;
        y  <= py;
        cr <= cfg.julia_re;
        ci <= cfg.julia_im;
      end else begin
        x  <= '0;
        y  <= '0;
        cr <= px;
        ci <= py;
      end
    end
    if (state == S_MYY) begin
      xx <= prod;
    end
    if (state == S_MXY) begin
      xx <= diff[63:0];
    end
    if (state == S_UPD) begin
      x     <= x_new;
      y     <= y_new;
      count <= count_inc;
    end
    if (fin) begin
      out_col      <= col_q;
      out_row      <= row_q;
      escape_count <= fin_count;
      in_set       <= (fin_count == cfg.max_iter);
    end
  end

  assign busy = (state != S_IDLE);

endmodule

[src/etf_mul.sv]
// shared 32x32 signed multiplier with registered 64-bit product
// no dependencies
module etf_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);

  logic signed [63:0] a_ext;
  logic signed [63:0] b_ext;

  assign a_ext = {{32{a[31]}}, a};
  assign b_ext = {{32{b[31]}}, b};

  always_ff @(posedge clk) begin
    p <= a_ext * b_ext;
  end

endmodule

[src/etf_cfg.sv]
// configuration register file for the escape time fractal pixel core
// depends on etf_pkg
module etf_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [etf_pkg::CFG_IDX_W-1:0]  index,
  input  logic [etf_pkg::CFG_DAT_W-1:0]  data,
  output etf_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= etf_pkg::MODE_MANDELBROT;
      cfg.max_iter <= etf_pkg::RST_MAX_ITER;
      cfg.x_origin <= etf_pkg::RST_X_ORIGIN;
      cfg.y_origin <= etf_pkg::RST_Y_ORIGIN;
      cfg.x_step   <= etf_pkg::RST_X_STEP;
      cfg.y_step   <= etf_pkg::RST_Y_STEP;
      cfg.julia_re <= '0;
      cfg.julia_im <= '0;
    end else if (we) begin
      unique case (index)
        etf_pkg::REG_MODE:     cfg.mode     <= data[0];
        etf_pkg::REG_MAX_ITER: cfg.max_iter <= data[15:0];
        etf_pkg::REG_X_ORIGIN: cfg.x_origin <= data;
        etf_pkg::REG_Y_ORIGIN: cfg.y_origin <= data;
        etf_pkg::REG_X_STEP:   cfg.x_step   <= data[30:0];
        etf_pkg::REG_Y_STEP:   cfg.y_step   <= data[30:0];
        etf_pkg::REG_JULIA_RE: cfg.julia_re <= data;
        etf_pkg::REG_JULIA_IM: cfg.julia_im <= data;
        default: ;
      endcase
    end
  end

endmodule

[src/etf_chk.sv]
// port level checker for the escape time fractal pixel core, bound to the top
// depends on escape_time_fractal_pixel_core_macros.svh
`include "escape_time_fractal_pixel_core_macros.svh"

module etf_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done
);

  `ETF_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted transaction did not raise busy")
  `ETF_ASSERT(a_done_idle, done |-> !busy, "result shown while still busy")
  `ETF_ASSERT(a_done_pulse, done |=> !done, "result strobe longer than one cycle")
  `ETF_ASSERT(a_fall_done, ($fell(busy) && !$past(rst)) |-> done, "busy dropped with no result")
  `ETF_ASSERT_ALWAYS(a_reset_quiet, rst |=> (!busy && !done), "reset left the core active")

endmodule

bind escape_time_fractal_pixel_core etf_chk u_etf_chk (.*);
